[sv/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg
// Shared types and codes for the sorted multiset table: command and status
// codes, fixed field widths and the sequencer state encoding.
// ----------------------------------------------------------------------------
package smt_pkg;

   localparam int CMD_W       = 2;
   localparam int VALUE_W     = 32;
   localparam int POS_W       = 4;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 5;

   typedef logic [CMD_W-1:0]    cmd_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam cmd_type CMD_INSERT = 2'd0;
   localparam cmd_type CMD_DELETE = 2'd1;
   localparam cmd_type CMD_READ   = 2'd2;

   localparam status_type STATUS_DONE      = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_BAD_POS   = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_RUN    = 4'b0010,
      ST_RDWAIT = 4'b0100,
      ST_FIN    = 4'b1000
   } state_type;

endpackage

[sv/smt_mem.sv]
// ----------------------------------------------------------------------------
// smt_mem
// Entry storage: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module smt_mem #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = $clog2(TABLE_DEPTH)
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [IDX_W-1:0]                 wr_addr,
   input  logic signed [smt_pkg::VALUE_W-1:0] wr_data,
   input  logic                             rd_en,
   input  logic [IDX_W-1:0]                 rd_addr,
   output logic signed [smt_pkg::VALUE_W-1:0] rd_data_ff
);

   logic signed [smt_pkg::VALUE_W-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

[sv/smt_ctrl.sv]
// ----------------------------------------------------------------------------
// smt_ctrl
// Command sequencer: walks the stored entries through the memory port one
// per cycle, rippling a carried entry up for insert or down for delete,
// and holds the result in an output register.
// ----------------------------------------------------------------------------
module smt_ctrl #(
   parameter int TABLE_DEPTH = 16,
   parameter int IDX_W       = $clog2(TABLE_DEPTH),
   parameter int CNT_W       = $clog2(TABLE_DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [smt_pkg::CMD_W-1:0]            req_cmd,
   input  logic signed [smt_pkg::VALUE_W-1:0]   req_value,
   input  logic [smt_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [smt_pkg::STATUS_W-1:0]         rsp_status,
   output logic [smt_pkg::COUNT_OUT_W-1:0]      rsp_entry_count,
   output logic signed [smt_pkg::VALUE_W-1:0]   rsp_read_value,
   output logic                                 mem_wr_en,
   output logic [IDX_W-1:0]                     mem_wr_addr,
   output logic signed [smt_pkg::VALUE_W-1:0]   mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [IDX_W-1:0]                     mem_rd_addr,
   input  logic signed [smt_pkg::VALUE_W-1:0]   mem_rd_data
);

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_DEPTH);
   localparam int               EXT_W      = CNT_W + smt_pkg::POS_W;

   smt_pkg::state_type                 state_ff, state_in;
   smt_pkg::cmd_type                   cmd_ff, cmd_in;
   logic signed [smt_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [CNT_W-1:0]                   idx_ff, idx_in;
   logic [IDX_W-1:0]                   didx_ff, didx_in;
   logic                               dv_ff, dv_in;
   logic signed [smt_pkg::VALUE_W-1:0] carry_ff, carry_in;
   logic                               hit_ff, hit_in;
   logic [CNT_W-1:0]                   count_ff, count_in;
   smt_pkg::status_type                status_ff, status_in;
   logic signed [smt_pkg::VALUE_W-1:0] result_ff, result_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   smt_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [smt_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;
   logic signed [smt_pkg::VALUE_W-1:0] rsp_read_ff, rsp_read_in;

   logic [EXT_W-1:0] pos_ext;
   logic [EXT_W-1:0] cnt_ext;

   assign pos_ext = EXT_W'(req_position);
   assign cnt_ext = EXT_W'(count_ff);

   assign req_ready       = (state_ff == smt_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_read_value  = rsp_read_ff;

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      value_in      = value_ff;
      idx_in        = idx_ff;
      didx_in       = didx_ff;
      dv_in         = dv_ff;
      carry_in      = carry_ff;
      hit_in        = hit_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      result_in     = result_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_read_in   = rsp_read_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = didx_ff;
      mem_wr_data   = carry_ff;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = idx_ff[IDX_W-1:0];

      unique case (state_ff)
         smt_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd_in    = req_cmd;
               value_in  = req_value;
               idx_in    = '0;
               dv_in     = 1'b0;
               hit_in    = 1'b0;
               result_in = '0;
               status_in = smt_pkg::STATUS_DONE;
               state_in  = smt_pkg::ST_FIN;
               unique case (req_cmd)
                  smt_pkg::CMD_INSERT: begin
                     if (count_ff >= FULL_COUNT) begin
                        status_in = smt_pkg::STATUS_FULL;
                     end else begin
                        state_in = smt_pkg::ST_RUN;
                     end
                  end
                  smt_pkg::CMD_DELETE: begin
                     if (count_ff == '0) begin
                        status_in = smt_pkg::STATUS_NOT_FOUND;
                     end else begin
                        state_in = smt_pkg::ST_RUN;
                     end
                  end
                  smt_pkg::CMD_READ: begin
                     if (pos_ext >= cnt_ext) begin
                        status_in = smt_pkg::STATUS_BAD_POS;
                     end else begin
                        mem_rd_en   = 1'b1;
                        mem_rd_addr = pos_ext[IDX_W-1:0];
                        state_in    = smt_pkg::ST_RDWAIT;
                     end
                  end
                  default: begin
                     status_in = smt_pkg::STATUS_DONE;
                  end
               endcase
            end
         end

         smt_pkg::ST_RUN: begin
            dv_in = 1'b0;
            // issue the next read while the previous entry is handled
            if (idx_ff != count_ff) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[IDX_W-1:0];
               idx_in      = idx_ff + 1'b1;
               dv_in       = 1'b1;
               didx_in     = idx_ff[IDX_W-1:0];
            end

            if (dv_ff) begin
               if (cmd_ff == smt_pkg::CMD_INSERT) begin
                  if (!hit_ff && (mem_rd_data >= value_ff)) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = didx_ff;
                     mem_wr_data = value_ff;
                     carry_in    = mem_rd_data;
                     hit_in      = 1'b1;
                  end else if (hit_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = didx_ff;
                     mem_wr_data = carry_ff;
                     carry_in    = mem_rd_data;
                  end
               end else begin
                  // delete: after the first match each entry moves down one
                  if (!hit_ff && (mem_rd_data == value_ff)) begin
                     hit_in = 1'b1;
                  end else if (hit_ff) begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = didx_ff - 1'b1;
                     mem_wr_data = mem_rd_data;
                  end
               end
            end

            if ((idx_ff == count_ff) && !dv_ff) begin
               state_in = smt_pkg::ST_FIN;
               if (cmd_ff == smt_pkg::CMD_INSERT) begin
                  // new top entry is the last carried one, or the value itself
                  mem_wr_en   = 1'b1;
                  mem_wr_addr = count_ff[IDX_W-1:0];
                  mem_wr_data = hit_ff ? carry_ff : value_ff;
                  count_in    = count_ff + 1'b1;
               end else if (hit_ff) begin
                  count_in = count_ff - 1'b1;
               end else begin
                  status_in = smt_pkg::STATUS_NOT_FOUND;
               end
            end
         end

         smt_pkg::ST_RDWAIT: begin
            result_in = mem_rd_data;
            state_in  = smt_pkg::ST_FIN;
         end

         smt_pkg::ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = cnt_ext[smt_pkg::COUNT_OUT_W-1:0];
               rsp_read_in   = result_ff;
               state_in      = smt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = smt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smt_pkg::ST_IDLE;
         count_ff     <= '0;
         dv_ff        <= 1'b0;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dv_ff        <= dv_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      value_ff      <= value_in;
      idx_ff        <= idx_in;
      didx_ff       <= didx_in;
      carry_ff      <= carry_in;
      status_ff     <= status_in;
      result_ff     <= result_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_read_ff   <= rsp_read_in;
   end

endmodule

[sv/sorted_multiset_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit
// Bounded table of signed 32-bit values kept in ascending order with
// duplicates, supporting insert, delete of first match and read by position.
// ----------------------------------------------------------------------------
// usage:
//   req_* carries one command item (cmd, value, position) under valid/ready;
//   rsp_* returns exactly one result item per command (status, entry count
//   after the command, read value) under valid/ready.
//   the entries live in a single memory with registered read data; insert
//   and delete walk the stored entries through its port, one entry a cycle,
//   moving each later entry by one slot on the way.
//   a full insert, an empty delete, a read of a bad position or an unused
//   code goes straight to the result state; a read first waits in a state
//   for the memory data; inserts and deletes walk the stored entries in the
//   run state first. req_ready is high only between commands, so one item
//   is in work at a time and the next can be taken in the cycle after the
//   result is loaded.
//   the finished result sits in an output register, so the next item is
//   taken while it waits; if rsp_ready stays low, that next item completes
//   and then holds until the output register frees up.
//   reset empties the table at once (count goes to zero); the memory itself
//   is not swept, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
module sorted_multiset_table_unit #(
   parameter int TABLE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [smt_pkg::CMD_W-1:0]           req_cmd,
   input  logic signed [smt_pkg::VALUE_W-1:0]  req_value,
   input  logic [smt_pkg::POS_W-1:0]           req_position,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [smt_pkg::STATUS_W-1:0]        rsp_status,
   output logic [smt_pkg::COUNT_OUT_W-1:0]     rsp_entry_count,
   output logic signed [smt_pkg::VALUE_W-1:0]  rsp_read_value
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   logic                               mem_wr_en;
   logic [IDX_W-1:0]                   mem_wr_addr;
   logic signed [smt_pkg::VALUE_W-1:0] mem_wr_data;
   logic                               mem_rd_en;
   logic [IDX_W-1:0]                   mem_rd_addr;
   logic signed [smt_pkg::VALUE_W-1:0] mem_rd_data;

   smt_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .rsp_read_value  (rsp_read_value),
      .mem_wr_en       (mem_wr_en),
      .mem_wr_addr     (mem_wr_addr),
      .mem_wr_data     (mem_wr_data),
      .mem_rd_en       (mem_rd_en),
      .mem_rd_addr     (mem_rd_addr),
      .mem_rd_data     (mem_rd_data)
   );

   smt_mem #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_mem (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

[test/sorted_multiset_table_unit_test.sv]
// ----------------------------------------------------------------------------
// sorted_multiset_table_unit_test
// Self-checking testbench for the sorted multiset table. A short table of
// directed commands covers empty and full tables, the value extremes,
// duplicates, misses and the unused command code. It is followed by random
// fill and drain phases. Each accepted command is run through a local model
// of the table, and every result item is compared against it in order. Both
// handshakes idle at random, and one long receiver hold-off backs up the input.
// ----------------------------------------------------------------------------
module sorted_multiset_table_unit_test;

   localparam int TABLE_DEPTH   = 16;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int IDLE_PERCENT  = 6;
   localparam int HOLD_AT_ITEM  = 400;
   localparam int HOLD_CYCLES   = 150;
   localparam int QUIET_FROM    = 900;
   localparam int QUIET_TO      = 1200;
   localparam int PHASE_LEN     = 60;
   localparam int MAX_REPORTS   = 10;
   localparam int DIRECTED_N    = 25;

   localparam smt_pkg::cmd_type CMD_UNUSED = 2'd3;

   localparam logic [smt_pkg::VALUE_W-1:0] VALUE_MIN = 32'h8000_0000;
   localparam logic [smt_pkg::VALUE_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

   typedef struct {
      smt_pkg::status_type                   status;
      logic [smt_pkg::COUNT_OUT_W-1:0]       entry_count;
      logic signed [smt_pkg::VALUE_W-1:0]    read_value;
   } table_result_type;

   typedef struct packed {
      smt_pkg::cmd_type                cmd;
      logic [smt_pkg::VALUE_W-1:0]     value;
      logic [smt_pkg::POS_W-1:0]       position;
      logic                            typed;
      smt_pkg::status_type             status;
      logic [smt_pkg::COUNT_OUT_W-1:0] entry_count;
      logic [smt_pkg::VALUE_W-1:0]     read_value;
   } stim_row_type;

   // rows with typed set carry their own expected result
   localparam stim_row_type DIRECTED_ROWS [0:DIRECTED_N-1] = '{
      '{smt_pkg::CMD_READ,   32'd0,         4'd0,  1'b1, smt_pkg::STATUS_BAD_POS,
        5'd0,  32'd0},
      '{smt_pkg::CMD_DELETE, 32'd5,         4'd0,  1'b1, smt_pkg::STATUS_NOT_FOUND,
        5'd0,  32'd0},
      '{CMD_UNUSED,          32'd7,         4'd3,  1'b1, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, VALUE_MAX,     4'd0,  1'b1, smt_pkg::STATUS_DONE,
        5'd1,  32'd0},
      '{smt_pkg::CMD_INSERT, VALUE_MIN,     4'd15, 1'b1, smt_pkg::STATUS_DONE,
        5'd2,  32'd0},
      '{smt_pkg::CMD_READ,   32'd0,         4'd0,  1'b1, smt_pkg::STATUS_DONE,
        5'd2,  VALUE_MIN},
      '{smt_pkg::CMD_READ,   32'hFFFF_FFFF, 4'd1,  1'b1, smt_pkg::STATUS_DONE,
        5'd2,  VALUE_MAX},
      '{smt_pkg::CMD_INSERT, 32'd0,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_DELETE, 32'd0,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd0,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd0,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd1,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, VALUE_MIN,     4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, VALUE_MAX,     4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'hFFFF_FF9C, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd100,       4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'h4000_0000, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'hC000_0000, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd3,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd3,         4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'hFFFF_FFF9, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'h7FFF_FFFE, 4'd0,  1'b0, smt_pkg::STATUS_DONE,
        5'd0,  32'd0},
      '{smt_pkg::CMD_INSERT, 32'd42,        4'd0,  1'b1, smt_pkg::STATUS_FULL,
        5'd16, 32'd0},
      '{smt_pkg::CMD_READ,   32'd0,         4'd15, 1'b1, smt_pkg::STATUS_DONE,
        5'd16, VALUE_MAX}
   };

   logic                                   clock;
   logic                                   reset;
   logic                                   req_valid;
   logic                                   req_ready;
   logic [smt_pkg::CMD_W-1:0]              req_cmd;
   logic signed [smt_pkg::VALUE_W-1:0]     req_value;
   logic [smt_pkg::POS_W-1:0]              req_position;
   logic                                   rsp_valid;
   logic                                   rsp_ready;
   logic [smt_pkg::STATUS_W-1:0]           rsp_status;
   logic [smt_pkg::COUNT_OUT_W-1:0]        rsp_entry_count;
   logic signed [smt_pkg::VALUE_W-1:0]     rsp_read_value;

   // local copy of the table
   logic signed [smt_pkg::VALUE_W-1:0]     model_entries [TABLE_DEPTH];
   int                                     model_count;

   table_result_type                       pending_results [$];
   table_result_type                       expected_result;
   int                                     items_accepted;
   int                                     mismatch_count;
   int                                     cycle_count;
   int                                     hold_left;
   bit                                     hold_done;

   sorted_multiset_table_unit #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_value      (req_value),
      .req_position   (req_position),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_entry_count(rsp_entry_count),
      .rsp_read_value (rsp_read_value)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // applies one command to the local table and returns its result item
   function automatic table_result_type apply_table_command(smt_pkg::cmd_type cmd,
         logic signed [smt_pkg::VALUE_W-1:0] value, logic [smt_pkg::POS_W-1:0] position);
      table_result_type res;
      int               slot;
      res.status     = smt_pkg::STATUS_DONE;
      res.read_value = '0;
      slot = 0;
      case (cmd)
         smt_pkg::CMD_INSERT: begin
            if (model_count >= TABLE_DEPTH) begin
               res.status = smt_pkg::STATUS_FULL;
            end else begin
               while (slot < model_count && model_entries[slot] < value) slot++;
               for (int k = model_count; k > slot; k--)
                  model_entries[k] = model_entries[k-1];
               model_entries[slot] = value;
               model_count++;
            end
         end
         smt_pkg::CMD_DELETE: begin
            while (slot < model_count && model_entries[slot] != value) slot++;
            if (slot >= model_count) begin
               res.status = smt_pkg::STATUS_NOT_FOUND;
            end else begin
               for (int k = slot; k + 1 < model_count; k++)
                  model_entries[k] = model_entries[k+1];
               model_count--;
               model_entries[model_count] = '0;
            end
         end
         smt_pkg::CMD_READ: begin
            if (int'(position) >= model_count) begin
               res.status = smt_pkg::STATUS_BAD_POS;
            end else begin
               res.read_value = model_entries[position];
            end
         end
         default: ;
      endcase
      res.entry_count = model_count[smt_pkg::COUNT_OUT_W-1:0];
      return res;
   endfunction

   // half the draws fall in a narrow band around zero so deletes hit and duplicates pile up
   function automatic logic signed [smt_pkg::VALUE_W-1:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50) return $signed($urandom_range(20)) - 10;
      if (roll < 62) begin
         case ($urandom_range(5))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2:       return VALUE_MIN + 1;
            3:       return VALUE_MAX - 1;
            4:       return 32'hFFFF_FFFF;
            default: return 32'd0;
         endcase
      end
      return $urandom;
   endfunction

   function automatic bit quiet_stretch();
      return items_accepted >= QUIET_FROM && items_accepted < QUIET_TO;
   endfunction

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic offer_command(smt_pkg::cmd_type cmd,
         logic signed [smt_pkg::VALUE_W-1:0] value,
         logic [smt_pkg::POS_W-1:0] position, bit typed,
         table_result_type typed_result);
      table_result_type predicted;
      while (!quiet_stretch() && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_cmd      <= cmd;
      req_value    <= value;
      req_position <= position;
      do @(posedge clock); while (!req_ready);
      predicted = apply_table_command(cmd, value, position);
      pending_results.push_back(typed ? typed_result : predicted);
      items_accepted++;
      @(negedge clock);
   endtask

   task automatic log_mismatch(string reason);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t %s: got status %0d count %0d value %0d",
                  $time, reason, rsp_status, rsp_entry_count, rsp_read_value,
                  ", expected status %0d count %0d value %0d",
                  expected_result.status, expected_result.entry_count,
                  expected_result.read_value);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            expected_result = '{smt_pkg::STATUS_DONE, '0, '0};
            log_mismatch("result item with nothing pending");
         end else begin
            expected_result = pending_results.pop_front();
            if (rsp_status !== expected_result.status ||
                rsp_entry_count !== expected_result.entry_count ||
                rsp_read_value !== expected_result.read_value)
               log_mismatch("result mismatch");
         end
      end
   end

   // receiver: random stalls, one long hold-off, and a stall-free stretch
   initial begin
      rsp_ready = 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else if (!hold_done && items_accepted >= HOLD_AT_ITEM) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= quiet_stretch() || $urandom_range(99) >= IDLE_PERCENT;
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("sorted_multiset_table_unit_test: FAIL");
      $finish;
   end

   initial begin
      table_result_type                   typed_result;
      smt_pkg::cmd_type                   cmd;
      logic signed [smt_pkg::VALUE_W-1:0] value;
      logic [smt_pkg::POS_W-1:0]          position;
      logic [31:0]                        draw;
      bit                                 filling;
      int                                 roll;

      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = smt_pkg::CMD_INSERT;
      req_value      = '0;
      req_position   = '0;
      items_accepted = 0;
      mismatch_count = 0;
      model_count    = 0;
      filling        = 1'b0;
      foreach (model_entries[i]) model_entries[i] = '0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIRECTED_N; i++) begin
         typed_result.status      = DIRECTED_ROWS[i].status;
         typed_result.entry_count = DIRECTED_ROWS[i].entry_count;
         typed_result.read_value  = DIRECTED_ROWS[i].read_value;
         offer_command(DIRECTED_ROWS[i].cmd, DIRECTED_ROWS[i].value,
                       DIRECTED_ROWS[i].position, DIRECTED_ROWS[i].typed,
                       typed_result);
      end

      // alternate fill and drain phases so the table swings from empty to full
      typed_result = '{smt_pkg::STATUS_DONE, '0, '0};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_LEN == 0) filling = !filling;
         roll = $urandom_range(99);
         if (roll < 5)
            cmd = CMD_UNUSED;
         else if (roll < (filling ? 62 : 25))
            cmd = smt_pkg::CMD_INSERT;
         else if (roll < (filling ? 82 : 78))
            cmd = smt_pkg::CMD_DELETE;
         else
            cmd = smt_pkg::CMD_READ;
         value = pick_value();
         if (cmd == smt_pkg::CMD_DELETE && model_count > 0 && $urandom_range(3) != 0)
            value = model_entries[$urandom_range(model_count - 1)];
         draw = $urandom_range(15);
         if (cmd == smt_pkg::CMD_READ && model_count > 0 && $urandom_range(4) != 0)
            draw = $urandom_range(model_count - 1);
         position = draw[smt_pkg::POS_W-1:0];
         offer_command(cmd, value, position, 1'b0, typed_result);
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("sorted_multiset_table_unit_test: PASS");
      else
         $display("sorted_multiset_table_unit_test: FAIL");
      $finish;
   end

endmodule
